// ===== hw/rtl/sqrg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Squelch ramp gate package
// Shared types and constants: sequencer states, squelch modes, the fixed-point
// constants of the raised-cosine envelope and the register indexes.
// ----------------------------------------------------------------------------
package sqrg_pkg;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_POLY,
        ST_LOAD,
        ST_SCALE,
        ST_EMIT
    } seq_state_t;

    // Squelch modes.
    typedef enum logic [1:0] {
        MODE_MUTED   = 2'd0,
        MODE_ATTACK  = 2'd1,
        MODE_UNMUTED = 2'd2,
        MODE_DECAY   = 2'd3
    } squelch_mode_t;

    // Configuration port.
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RAMP_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GATE_ENABLE = 1'b1;

    // Envelope arithmetic.
    localparam int GAIN_WIDTH  = 16;
    localparam int PHASE_BITS  = 24;
    localparam int MUL_WIDTH   = 32;
    localparam int POLY_STEPS  = 8;
    localparam logic [GAIN_WIDTH-1:0] GAIN_ONE  = 16'h8000;
    localparam logic [GAIN_WIDTH-1:0] GAIN_ZERO = 16'h0000;
    localparam logic [MUL_WIDTH-1:0] Q30_PI = 32'd3373259426;
    localparam logic [MUL_WIDTH-1:0] K1 = 32'd536870912;
    localparam logic [MUL_WIDTH-1:0] K2 = 32'd44739243;
    localparam logic [MUL_WIDTH-1:0] K3 = 32'd1491308;
    localparam logic [MUL_WIDTH-1:0] K4 = 32'd26631;
    localparam logic [MUL_WIDTH-1:0] K5 = 32'd296;
    localparam logic [MUL_WIDTH-1:0] K6 = 32'd2;

    // Handshake between the sequencer and a serial arithmetic unit.
    typedef struct packed {
        logic start;
        logic done;
    } unit_ctrl_t;

    // Series coefficient that follows a given multiply step of the Horner chain.
    function automatic logic [MUL_WIDTH-1:0] horner_coef(input logic [2:0] step);
        logic [MUL_WIDTH-1:0] coef;
        case (step)
            3'd2:    coef = K5;
            3'd3:    coef = K4;
            3'd4:    coef = K3;
            3'd5:    coef = K2;
            default: coef = K1;
        endcase
        return coef;
    endfunction

endpackage

// ===== hw/rtl/sqrg_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Squelch ramp gate phase divider
// Restoring divider, one quotient bit per cycle: phase = floor(k * 2^24 / n),
// with k clamped to n so that the phase never exceeds 2^24.
// ----------------------------------------------------------------------------
module sqrg_div #(
    parameter int RAMP_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [RAMP_WIDTH-1:0]          k,
    input  logic [RAMP_WIDTH-1:0]          n,
    output logic                           done,
    output logic [sqrg_pkg::PHASE_BITS:0]  phase
);

    localparam int PB = sqrg_pkg::PHASE_BITS;
    localparam int CW = $clog2(PB + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CW-1:0]   cnt_reg;
    logic [RAMP_WIDTH-1:0] rem_reg;
    logic [PB:0]     quo_reg;

    logic [RAMP_WIDTH:0] rem_dbl;
    logic [RAMP_WIDTH:0] rem_sub;
    logic                fits;

    // One trial subtraction of the doubled remainder.
    always_comb
    begin
        rem_dbl = {rem_reg, 1'b0};
        fits    = (rem_dbl >= {1'b0, n});
        rem_sub = rem_dbl - {1'b0, n};
    end

    // Iteration registers; a ramp counter at or above the ramp length skips the iterations.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (k >= n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CW'(PB);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= k;
            if (k >= n)
                quo_reg <= (PB + 1)'(1) << PB;
            else
                quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub[RAMP_WIDTH-1:0] : rem_dbl[RAMP_WIDTH-1:0];
            quo_reg <= {quo_reg[PB-1:0], fits};
        end
    end

    assign done  = done_reg;
    assign phase = quo_reg;

endmodule

// ===== hw/rtl/sqrg_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Squelch ramp gate serial multiplier
// Unsigned 32 x 32 shift-and-add multiplier, one multiplier bit per cycle,
// using one 32-bit adder; the 64-bit product holds from done until next start.
// ----------------------------------------------------------------------------
module sqrg_mul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [sqrg_pkg::MUL_WIDTH-1:0]      a,
    input  logic [sqrg_pkg::MUL_WIDTH-1:0]      b,
    output logic                                done,
    output logic [2*sqrg_pkg::MUL_WIDTH-1:0]    product
);

    localparam int MW = sqrg_pkg::MUL_WIDTH;
    localparam int CW = $clog2(MW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [MW-1:0] a_reg;
    logic [MW-1:0] hi_reg;
    logic [MW-1:0] lo_reg;
    logic [MW:0]   sum;

    // Add the multiplicand when the current multiplier bit is set.
    always_comb
    begin
        sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : {(MW + 1){1'b0}});
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(MW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial product shifts right one bit per step.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[MW:1];
            lo_reg <= {sum[0], lo_reg[MW-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

// ===== hw/rtl/squelch_ramp_gate_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Squelch ramp gate core
// Squelch gate with raised-cosine attack and decay ramps on complex samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (sample_i, sample_q, mute_request) enter on in_valid/in_ready;
//   result items (out_i, out_q and the burst marks) leave on out_valid/out_ready.
//   An item gives one result, or none while muted with gate_enable set.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle;
//   writing ramp_length reloads the envelope.
// Sequencing:
//   One item at a time. An item that gives a result goes through load, 16
//   serial multiply steps for the sample scaling and output; an item inside
//   a ramp first computes the envelope: the divider for the phase, then
//   8 serial multiplies for the cosine series. Items that give no result
//   and need no envelope leave the sequencer idle, ready for the next item.
// Reset and stall:
//   Reset puts the gate in muted mode with a start mark armed. A finished
//   result waits in the output register while the next item is accepted and
//   worked on; the block holds only when a second result is ready before
//   the first has been taken.
// ----------------------------------------------------------------------------
module squelch_ramp_gate_core #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int RAMP_WIDTH   = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [sqrg_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [sqrg_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]         sample_i,
    input  logic signed [SAMPLE_WIDTH-1:0]         sample_q,
    input  logic                                   mute_request,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]         out_i,
    output logic signed [SAMPLE_WIDTH-1:0]         out_q,
    output logic                                   start_of_burst,
    output logic                                   end_of_burst,
    output logic                                   is_unmuted
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int GW = sqrg_pkg::GAIN_WIDTH;
    localparam int PB = sqrg_pkg::PHASE_BITS;
    localparam int MW = sqrg_pkg::MUL_WIDTH;
    localparam int SCW = $clog2(GW + 1);

    // Control state.
    sqrg_pkg::seq_state_t    state_reg;
    sqrg_pkg::seq_state_t    state_next;
    sqrg_pkg::squelch_mode_t mode_reg;
    logic [RAMP_WIDTH-1:0]   ramp_length_reg;
    logic                    gate_enable_reg;
    logic [RAMP_WIDTH-1:0]   pos_reg;
    logic [GW-1:0]           gain_reg;
    logic                    start_pending_reg;
    logic                    start_waiting_reg;
    logic                    end_pending_reg;
    logic                    emit_hold_reg;
    logic                    muted_hold_reg;
    logic                    sob_hold_reg;
    logic                    eob_hold_reg;
    logic                    unm_hold_reg;
    logic                    mul_go_reg;
    logic [2:0]              step_reg;
    logic [SCW-1:0]          scnt_reg;
    logic                    out_valid_reg;

    // Payload registers.
    logic signed [SW-1:0]    smp_i_reg;
    logic signed [SW-1:0]    smp_q_reg;
    logic [PB-1:0]           ph_reg;
    logic                    flip_reg;
    logic [MW-1:0]           y_reg;
    logic [MW-1:0]           u_reg;
    logic [MW-1:0]           t_reg;
    logic [GW-1:0]           gsh_reg;
    logic [SW:0]             hi_i_reg;
    logic [SW:0]             hi_q_reg;
    logic [GW-1:0]           lo_i_reg;
    logic [GW-1:0]           lo_q_reg;
    logic signed [SW-1:0]    out_i_reg;
    logic signed [SW-1:0]    out_q_reg;
    logic                    sob_reg;
    logic                    eob_reg;
    logic                    unm_reg;

    // Step decision for the accepted item.
    sqrg_pkg::squelch_mode_t mode_new;
    logic [RAMP_WIDTH-1:0]   pos_new;
    logic [RAMP_WIDTH-1:0]   pos_inc;
    logic [RAMP_WIDTH-1:0]   env_k;
    logic                    sp_new;
    logic                    sw_new;
    logic                    ep_new;
    logic                    need_env;
    logic                    gain_load;
    logic [GW-1:0]           gain_val;
    logic                    emit;

    // Sequencer strobes.
    logic                    in_fire;
    logic                    emit_load;
    sqrg_pkg::unit_ctrl_t    div_ctrl;
    sqrg_pkg::unit_ctrl_t    mul_ctrl;

    // Arithmetic units and their operands.
    logic [PB:0]             phase;
    logic [MW-1:0]           mul_a;
    logic [MW-1:0]           mul_b;
    logic [2*MW-1:0]         product;
    logic [2*MW-31:0]        prod_hi;
    logic [GW-1:0]           half;
    logic [SW+1:0]           sum_i;
    logic [SW+1:0]           sum_q;
    logic [SW+GW:0]          full_i;
    logic [SW+GW:0]          full_q;
    logic [SW+GW+1:0]        rnd_i;
    logic [SW+GW+1:0]        rnd_q;
    logic [RAMP_WIDTH-1:0]   cfg_ramp;

    assign in_fire  = in_valid && in_ready;
    assign cfg_ramp = RAMP_WIDTH'(cfg_data);

    // Mode transition, ramp counter and burst marks for one item.
    always_comb
    begin
        mode_new  = mode_reg;
        pos_new   = pos_reg;
        sp_new    = start_pending_reg;
        sw_new    = start_waiting_reg;
        ep_new    = end_pending_reg;
        need_env  = 1'b0;
        env_k     = pos_reg;
        gain_load = 1'b0;
        gain_val  = sqrg_pkg::GAIN_ZERO;
        pos_inc   = (pos_reg != '1) ? pos_reg + 1'b1 : pos_reg;
        case (mode_reg)
            sqrg_pkg::MODE_MUTED:
            begin
                if (!mute_request)
                begin
                    if (ramp_length_reg != '0)
                        mode_new = sqrg_pkg::MODE_ATTACK;
                    else
                    begin
                        mode_new = sqrg_pkg::MODE_UNMUTED;
                        sp_new   = 1'b1;
                    end
                end
            end
            sqrg_pkg::MODE_UNMUTED:
            begin
                if (start_pending_reg)
                begin
                    sp_new = 1'b0;
                    sw_new = 1'b1;
                end
                if (mute_request)
                begin
                    if (ramp_length_reg != '0)
                        mode_new = sqrg_pkg::MODE_DECAY;
                    else
                    begin
                        mode_new = sqrg_pkg::MODE_MUTED;
                        ep_new   = 1'b1;
                    end
                end
            end
            sqrg_pkg::MODE_ATTACK:
            begin
                pos_new = pos_inc;
                if (ramp_length_reg == '0 || pos_inc >= ramp_length_reg)
                begin
                    mode_new  = sqrg_pkg::MODE_UNMUTED;
                    sp_new    = 1'b1;
                    gain_load = 1'b1;
                    gain_val  = sqrg_pkg::GAIN_ONE;
                end
                else
                begin
                    need_env = 1'b1;
                    env_k    = pos_inc;
                end
            end
            default:
            begin
                if (ramp_length_reg == '0 || pos_reg == '0)
                begin
                    pos_new   = '0;
                    gain_load = 1'b1;
                end
                else
                begin
                    pos_new  = pos_reg - 1'b1;
                    need_env = 1'b1;
                    env_k    = pos_reg - 1'b1;
                end
                if (pos_new == '0)
                begin
                    mode_new = sqrg_pkg::MODE_MUTED;
                    ep_new   = 1'b1;
                end
            end
        endcase
        emit = !(mode_new == sqrg_pkg::MODE_MUTED && gate_enable_reg);
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sqrg_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (need_env)
                        state_next = sqrg_pkg::ST_DIV;
                    else if (emit)
                        state_next = sqrg_pkg::ST_LOAD;
                end
            end
            sqrg_pkg::ST_DIV:
            begin
                if (div_ctrl.done)
                    state_next = sqrg_pkg::ST_POLY;
            end
            sqrg_pkg::ST_POLY:
            begin
                if (mul_ctrl.done && step_reg == 3'(sqrg_pkg::POLY_STEPS - 1))
                    state_next = emit_hold_reg ? sqrg_pkg::ST_LOAD : sqrg_pkg::ST_IDLE;
            end
            sqrg_pkg::ST_LOAD:
                state_next = sqrg_pkg::ST_SCALE;
            sqrg_pkg::ST_SCALE:
            begin
                if (scnt_reg == SCW'(1))
                    state_next = sqrg_pkg::ST_EMIT;
            end
            sqrg_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = sqrg_pkg::ST_IDLE;
            end
            default:
                state_next = sqrg_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready       = (state_reg == sqrg_pkg::ST_IDLE);
        emit_load      = (state_reg == sqrg_pkg::ST_EMIT) && (!out_valid_reg || out_ready);
        div_ctrl.start = (state_reg == sqrg_pkg::ST_IDLE) && in_fire && need_env;
        mul_ctrl.start = mul_go_reg;
    end

    // Multiplier operands for each step of the envelope series.
    always_comb
    begin
        case (step_reg)
            3'd0:
            begin
                mul_a = MW'(ph_reg);
                mul_b = sqrg_pkg::Q30_PI;
            end
            3'd1:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            default:
            begin
                mul_a = u_reg;
                mul_b = t_reg;
            end
        endcase
        prod_hi = product[2*MW-1:30];
        half    = GW'((prod_hi + (2*MW-29)'(32768)) >> 16);
    end

    sqrg_div #(
        .RAMP_WIDTH (RAMP_WIDTH)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_ctrl.start),
        .k     (env_k),
        .n     (ramp_length_reg),
        .done  (div_ctrl.done),
        .phase (phase)
    );

    sqrg_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_ctrl.start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_ctrl.done),
        .product (product)
    );

    // Serial sample scaling: one gain bit per cycle for both parts.
    always_comb
    begin
        sum_i  = {hi_i_reg[SW], hi_i_reg}
               + (gsh_reg[0] ? {{2{smp_i_reg[SW-1]}}, smp_i_reg} : {(SW + 2){1'b0}});
        sum_q  = {hi_q_reg[SW], hi_q_reg}
               + (gsh_reg[0] ? {{2{smp_q_reg[SW-1]}}, smp_q_reg} : {(SW + 2){1'b0}});
        full_i = {hi_i_reg, lo_i_reg};
        full_q = {hi_q_reg, lo_q_reg};
        rnd_i  = {full_i[SW+GW], full_i} + (SW + GW + 2)'(16384);
        rnd_q  = {full_q[SW+GW], full_q} + (SW + GW + 2)'(16384);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= sqrg_pkg::ST_IDLE;
            mode_reg          <= sqrg_pkg::MODE_MUTED;
            ramp_length_reg   <= RAMP_WIDTH'(4);
            gate_enable_reg   <= 1'b0;
            pos_reg           <= '0;
            gain_reg          <= sqrg_pkg::GAIN_ZERO;
            start_pending_reg <= 1'b1;
            start_waiting_reg <= 1'b0;
            end_pending_reg   <= 1'b0;
            emit_hold_reg     <= 1'b0;
            muted_hold_reg    <= 1'b1;
            sob_hold_reg      <= 1'b0;
            eob_hold_reg      <= 1'b0;
            unm_hold_reg      <= 1'b0;
            mul_go_reg        <= 1'b0;
            step_reg          <= '0;
            scnt_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mul_go_reg <= 1'b0;

            // Configuration writes.
            if (cfg_we)
            begin
                if (cfg_index == sqrg_pkg::REG_RAMP_LENGTH)
                begin
                    ramp_length_reg <= cfg_ramp;
                    gain_reg <= (cfg_ramp == '0) ? sqrg_pkg::GAIN_ONE : sqrg_pkg::GAIN_ZERO;
                end
                else if (cfg_index == sqrg_pkg::REG_GATE_ENABLE)
                    gate_enable_reg <= cfg_data[0];
            end

            // Accepted item: step the gate and hold the result marks.
            if (in_fire)
            begin
                mode_reg          <= mode_new;
                pos_reg           <= pos_new;
                start_pending_reg <= sp_new;
                emit_hold_reg     <= emit;
                muted_hold_reg    <= (mode_new == sqrg_pkg::MODE_MUTED);
                unm_hold_reg      <= (mode_new == sqrg_pkg::MODE_UNMUTED)
                                  || (mode_new == sqrg_pkg::MODE_ATTACK);
                sob_hold_reg      <= sw_new;
                eob_hold_reg      <= ep_new;
                if (emit)
                begin
                    start_waiting_reg <= 1'b0;
                    end_pending_reg   <= 1'b0;
                end
                else
                begin
                    start_waiting_reg <= sw_new;
                    end_pending_reg   <= ep_new;
                end
                if (gain_load)
                    gain_reg <= gain_val;
            end

            // Envelope series sequencing.
            if (state_reg == sqrg_pkg::ST_DIV && div_ctrl.done)
            begin
                step_reg   <= '0;
                mul_go_reg <= 1'b1;
            end
            if (state_reg == sqrg_pkg::ST_POLY && mul_ctrl.done)
            begin
                if (step_reg == 3'(sqrg_pkg::POLY_STEPS - 1))
                    gain_reg <= flip_reg ? sqrg_pkg::GAIN_ONE - half : half;
                else
                begin
                    step_reg   <= step_reg + 1'b1;
                    mul_go_reg <= 1'b1;
                end
            end

            // Scaling step counter.
            if (state_reg == sqrg_pkg::ST_LOAD)
                scnt_reg <= SCW'(GW);
            else if (state_reg == sqrg_pkg::ST_SCALE)
                scnt_reg <= scnt_reg - 1'b1;

            // Output register.
            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            smp_i_reg <= sample_i;
            smp_q_reg <= sample_q;
        end

        // Fold the phase onto the first half of the ramp.
        if (state_reg == sqrg_pkg::ST_DIV && div_ctrl.done)
        begin
            flip_reg <= (phase > (PB + 1)'(1) << (PB - 1));
            if (phase > (PB + 1)'(1) << (PB - 1))
                ph_reg <= PB'(((PB + 1)'(1) << PB) - phase);
            else
                ph_reg <= phase[PB-1:0];
            t_reg <= sqrg_pkg::K6;
        end

        // Results of the envelope multiplies.
        if (state_reg == sqrg_pkg::ST_POLY && mul_ctrl.done)
        begin
            case (step_reg)
                3'd0:    y_reg <= product[PB+MW-1:PB];
                3'd1:    u_reg <= product[MW+29:30];
                3'd7:    t_reg <= t_reg;
                default: t_reg <= sqrg_pkg::horner_coef(step_reg) - product[MW+29:30];
            endcase
        end

        // Sample scaling.
        if (state_reg == sqrg_pkg::ST_LOAD)
        begin
            gsh_reg  <= muted_hold_reg ? sqrg_pkg::GAIN_ZERO : gain_reg;
            hi_i_reg <= '0;
            hi_q_reg <= '0;
            lo_i_reg <= '0;
            lo_q_reg <= '0;
        end
        else if (state_reg == sqrg_pkg::ST_SCALE)
        begin
            gsh_reg  <= gsh_reg >> 1;
            hi_i_reg <= sum_i[SW+1:1];
            hi_q_reg <= sum_q[SW+1:1];
            lo_i_reg <= {sum_i[0], lo_i_reg[GW-1:1]};
            lo_q_reg <= {sum_q[0], lo_q_reg[GW-1:1]};
        end

        // Round to nearest and hand the item to the output register.
        if (emit_load)
        begin
            out_i_reg <= rnd_i[SW+14:15];
            out_q_reg <= rnd_q[SW+14:15];
            sob_reg   <= sob_hold_reg;
            eob_reg   <= eob_hold_reg;
            unm_reg   <= unm_hold_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_i          = out_i_reg;
    assign out_q          = out_q_reg;
    assign start_of_burst = sob_reg;
    assign end_of_burst   = eob_reg;
    assign is_unmuted     = unm_reg;

endmodule

// ===== dv/tb_squelch_ramp_gate_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Squelch ramp gate core testbench
// Drives complex samples with mute requests in bursts and gaps, mirrors the
// squelch state machine and raised-cosine envelope in a local predictor, and
// compares every result item field by field under random output stalls.
// Ramp length and gating are changed between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_squelch_ramp_gate_core;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 400;

    typedef struct packed {
        logic signed [15:0] i;
        logic signed [15:0] q;
        logic               mute;
    } sample_item_t;

    typedef struct packed {
        logic signed [15:0] i;
        logic signed [15:0] q;
        logic               sob;
        logic               eob;
        logic               unmuted;
    } gated_sample_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [sqrg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [sqrg_pkg::CFG_DATA_WIDTH-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] sample_i = '0;
    logic signed [15:0] sample_q = '0;
    logic mute_request = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] out_i;
    logic signed [15:0] out_q;
    logic start_of_burst;
    logic end_of_burst;
    logic is_unmuted;

    sample_item_t  pending_samples[$];
    gated_sample_t expected_outputs[$];
    int mismatches = 0;
    int idle_cycles = 0;

    // Mirror of the gate state and its registers.
    logic [15:0]             ramp_len;
    logic                    gate_on;
    sqrg_pkg::squelch_mode_t mode;
    logic [15:0]             ramp_pos;
    logic [15:0]             gain;
    logic                    start_armed;
    logic                    end_armed;
    logic                    start_waiting;

    always #1 clk = ~clk;

    squelch_ramp_gate_core DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .sample_i(sample_i), .sample_q(sample_q), .mute_request(mute_request),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_i(out_i), .out_q(out_q),
        .start_of_burst(start_of_burst), .end_of_burst(end_of_burst),
        .is_unmuted(is_unmuted)
    );

    // Half raised cosine (1 - cos y) / 2 in Q15 for phases up to half scale.
    function automatic logic [15:0] half_cosine(input logic [63:0] ph);
        logic [63:0] y;
        logic [63:0] u;
        logic [63:0] t;
        y = (ph * 64'(sqrg_pkg::Q30_PI)) >> sqrg_pkg::PHASE_BITS;
        u = (y * y) >> 30;
        t = 64'(sqrg_pkg::K6);
        t = 64'(sqrg_pkg::K5) - ((u * t) >> 30);
        t = 64'(sqrg_pkg::K4) - ((u * t) >> 30);
        t = 64'(sqrg_pkg::K3) - ((u * t) >> 30);
        t = 64'(sqrg_pkg::K2) - ((u * t) >> 30);
        t = 64'(sqrg_pkg::K1) - ((u * t) >> 30);
        return 16'((((u * t) >> 30) + 64'd32768) >> 16);
    endfunction

    // Envelope at ramp counter k over a ramp of n samples, n nonzero.
    function automatic logic [15:0] ramp_envelope(input logic [63:0] k,
                                                  input logic [63:0] n);
        logic [63:0] ph;
        if (k > n)
            k = n;
        ph = (k << sqrg_pkg::PHASE_BITS) / n;
        if (ph <= (64'd1 << (sqrg_pkg::PHASE_BITS - 1)))
            return half_cosine(ph);
        return sqrg_pkg::GAIN_ONE - half_cosine((64'd1 << sqrg_pkg::PHASE_BITS) - ph);
    endfunction

    // Sample times envelope, rounded to nearest with ties upward.
    function automatic logic [15:0] apply_gain(input logic signed [15:0] s,
                                               input logic [15:0] g);
        longint v;
        v = longint'(s) * longint'(g) + 64'sd16384;
        v = v >>> 15;
        return v[15:0];
    endfunction

    task automatic write_register(input logic [sqrg_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                  input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == sqrg_pkg::REG_RAMP_LENGTH)
        begin
            ramp_len = val;
            gain = (val == 16'd0) ? sqrg_pkg::GAIN_ONE : sqrg_pkg::GAIN_ZERO;
        end
        else
        begin
            gate_on = val[0];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Advance the mirrored gate by one item and queue any result it gives.
    task automatic predict_gate_step(input sample_item_t it);
        gated_sample_t r;
        case (mode)
            sqrg_pkg::MODE_MUTED:
            begin
                if (!it.mute)
                begin
                    if (ramp_len != 0)
                        mode = sqrg_pkg::MODE_ATTACK;
                    else
                    begin
                        mode = sqrg_pkg::MODE_UNMUTED;
                        start_armed = 1'b1;
                    end
                end
            end
            sqrg_pkg::MODE_UNMUTED:
            begin
                if (start_armed)
                begin
                    start_armed = 1'b0;
                    start_waiting = 1'b1;
                end
                if (it.mute)
                begin
                    if (ramp_len != 0)
                        mode = sqrg_pkg::MODE_DECAY;
                    else
                    begin
                        mode = sqrg_pkg::MODE_MUTED;
                        end_armed = 1'b1;
                    end
                end
            end
            sqrg_pkg::MODE_ATTACK:
            begin
                if (ramp_pos != 16'hFFFF)
                    ramp_pos = ramp_pos + 16'd1;
                if (ramp_len == 0 || ramp_pos >= ramp_len)
                begin
                    mode = sqrg_pkg::MODE_UNMUTED;
                    start_armed = 1'b1;
                    gain = sqrg_pkg::GAIN_ONE;
                end
                else
                    gain = ramp_envelope(64'(ramp_pos), 64'(ramp_len));
            end
            default:
            begin
                if (ramp_len == 0 || ramp_pos == 0)
                begin
                    ramp_pos = 16'd0;
                    gain = sqrg_pkg::GAIN_ZERO;
                end
                else
                begin
                    ramp_pos = ramp_pos - 16'd1;
                    gain = ramp_envelope(64'(ramp_pos), 64'(ramp_len));
                end
                if (ramp_pos == 0)
                begin
                    mode = sqrg_pkg::MODE_MUTED;
                    end_armed = 1'b1;
                end
            end
        endcase
        if (!(mode == sqrg_pkg::MODE_MUTED && gate_on))
        begin
            r.i = (mode != sqrg_pkg::MODE_MUTED) ? apply_gain(it.i, gain) : 16'sd0;
            r.q = (mode != sqrg_pkg::MODE_MUTED) ? apply_gain(it.q, gain) : 16'sd0;
            r.sob = start_waiting;
            r.eob = end_armed;
            r.unmuted = (mode == sqrg_pkg::MODE_UNMUTED || mode == sqrg_pkg::MODE_ATTACK);
            start_waiting = 1'b0;
            end_armed = 1'b0;
            expected_outputs.push_back(r);
        end
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_sample(input logic [15:0] i, input logic [15:0] q, input logic m);
        sample_item_t it;
        it.i = i;
        it.q = q;
        it.mute = m;
        pending_samples.push_back(it);
    endtask

    task automatic queue_run(input int n, input logic m);
        for (int k = 0; k < n; k++)
            queue_sample(pick_sample(), pick_sample(), m);
    endtask

    // Block until every queued item is in and every result is out, then settle.
    task automatic wait_until_idle();
        while (pending_samples.size() != 0 || in_valid || expected_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        sample_item_t it;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                it.i = sample_i;
                it.q = sample_q;
                it.mute = mute_request;
                predict_gate_step(it);
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    it = pending_samples.pop_front();
                    sample_i <= it.i;
                    sample_q <= it.q;
                    mute_request <= it.mute;
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall behavior is drawn anew at regular intervals among always
    // ready, random and a fixed pattern.
    int stall_cycle = 0;
    int stall_style = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            stall_cycle <= stall_cycle + 1;
            if (stall_cycle % 300 == 299)
                stall_style <= $urandom_range(0, 2);
            case (stall_style)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                default: out_ready <= (stall_cycle % 8) < 3;
            endcase
        end
    end

    // Result checker and watchdog.
    always @(posedge clk)
    begin
        gated_sample_t want;
        gated_sample_t got;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                got.i = out_i;
                got.q = out_q;
                got.sob = start_of_burst;
                got.eob = end_of_burst;
                got.unmuted = is_unmuted;
                if (expected_outputs.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result item: i=%0d q=%0d", got.i, got.q);
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    if (got !== want)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display({"mismatch: exp i=%0d q=%0d sob=%b eob=%b unm=%b,",
                                      " got i=%0d q=%0d sob=%b eob=%b unm=%b"},
                                want.i, want.q, want.sob, want.eob, want.unmuted,
                                got.i, got.q, got.sob, got.eob, got.unmuted);
                    end
                end
            end
        end
    end

    // Stimulus: directed corners first, then random phases of well-formed bursts.
    initial
    begin
        int rl;
        int n;
        ramp_len = 16'd4;
        gate_on = 1'b0;
        mode = sqrg_pkg::MODE_MUTED;
        ramp_pos = 16'd0;
        gain = sqrg_pkg::GAIN_ZERO;
        start_armed = 1'b1;
        end_armed = 1'b0;
        start_waiting = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: full attack, extremes of the samples, then decay.
        queue_sample(16'h7FFF, 16'h8000, 1'b0);
        queue_sample(16'h8000, 16'h7FFF, 1'b0);
        queue_sample(16'hFFFF, 16'h0001, 1'b0);
        queue_sample(16'h0000, 16'hFFFF, 1'b0);
        queue_sample(16'h7FFF, 16'h8000, 1'b0);
        queue_sample(16'h8000, 16'h7FFF, 1'b1);
        queue_run(5, 1'b1);
        wait_until_idle();

        // Zero ramp with gating: instant switching, marks held while gated.
        write_register(sqrg_pkg::REG_RAMP_LENGTH, 16'd0);
        write_register(sqrg_pkg::REG_GATE_ENABLE, 16'd1);
        queue_run(2, 1'b0);
        queue_run(3, 1'b1);
        queue_run(2, 1'b0);
        wait_until_idle();

        // Ramp raised, then lowered, while the gate stays unmuted.
        write_register(sqrg_pkg::REG_RAMP_LENGTH, 16'd8);
        queue_run(3, 1'b0);
        wait_until_idle();
        write_register(sqrg_pkg::REG_RAMP_LENGTH, 16'd2);
        queue_run(2, 1'b0);
        wait_until_idle();

        // Ramp changes while unmuted, a decay from counter zero, then muted items.
        write_register(sqrg_pkg::REG_RAMP_LENGTH, 16'd8);
        queue_run(2, 1'b0);
        wait_until_idle();
        write_register(sqrg_pkg::REG_RAMP_LENGTH, 16'd0);
        queue_run(1, 1'b0);
        wait_until_idle();
        write_register(sqrg_pkg::REG_RAMP_LENGTH, 16'd3);
        queue_run(2, 1'b1);
        wait_until_idle();
        write_register(sqrg_pkg::REG_GATE_ENABLE, 16'd0);
        queue_run(2, 1'b1);
        wait_until_idle();
        write_register(sqrg_pkg::REG_RAMP_LENGTH, 16'd0);
        queue_run(2, 1'b1);
        wait_until_idle();

        // Longest ramp: only the first steps of the attack.
        write_register(sqrg_pkg::REG_RAMP_LENGTH, 16'hFFFF);
        queue_run(6, 1'b0);
        queue_run(3, 1'b1);
        wait_until_idle();

        // Random phases, mostly alternating mute and unmute runs.
        for (int ph = 0; ph < 8; ph++)
        begin
            case ($urandom_range(0, 5))
                0: rl = 0;
                1: rl = 1;
                default: rl = $urandom_range(2, 12);
            endcase
            write_register(sqrg_pkg::REG_RAMP_LENGTH, 16'(rl));
            write_register(sqrg_pkg::REG_GATE_ENABLE, 16'($urandom_range(0, 1)));
            n = 0;
            while (n < 70)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    queue_sample(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
                    n++;
                end
                else
                begin
                    int len;
                    len = $urandom_range(1, 2 * rl + 4);
                    queue_run(len, 1'b0);
                    n += len;
                    len = $urandom_range(1, 2 * rl + 4);
                    queue_run(len, 1'b1);
                    n += len;
                end
            end
            wait_until_idle();
        end

        if (mismatches == 0 && expected_outputs.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
